>>> hdl/dstd_pkg.sv
`default_nettype none
package dstd_pkg;

  // double constants
  localparam logic [63:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_NEG_ONE = 64'hBFF0_0000_0000_0000;
  localparam logic [63:0] DBL_INF     = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_QNAN    = 64'h7FF8_0000_0000_0000;

  localparam int BIG_W     = 800;  // holds 5^323 and the long-division remainder
  localparam int FRAC_MAX  = 15;
  localparam int DIV_STEPS = 56;   // quotient bits: 53 + guard + sticky room
  localparam int PROD_W    = 77;   // 24 x 53 significand product

  // character codes
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_UC_E  = 8'd69;
  localparam logic [7:0] CH_LC_E  = 8'd101;

  typedef struct packed {
    logic mant_acc;
    logic frac_inc;
    logic set_mneg;
    logic set_eneg;
    logic exp_load;
    logic exp_acc;
    logic start;
    logic use_exp;
    logic nv_step;
    logic div_init;
    logic div_step;
    logic rnd53;
    logic rnd24;
    logic mul_lo;
    logic mul_hi;
    logic np_step;
    logic prep_shift;
    logic shr_step;
    logic load_out;
    logic too_long;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic dig;
    logic spc;
    logic plus;
    logic minus;
    logic dot;
    logic elet;
    logic frac_full;
    logic mant_zero;
    logic v_norm;
    logic p_norm;
    logic shr_done;
    logic t_special;
  } stat_t;

  typedef logic [63:0] den_tbl_t [16];
  typedef logic [5:0]  lead_tbl_t [16];

  // bits needed for a value below 10^len
  function automatic int dec_bits(int len);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < len; i++) p = p * 10;
    return $clog2(p);
  endfunction

  // round a 64-bit significand window to double, nearest-even
  function automatic logic [63:0] round_dbl(logic [63:0] t, logic sticky, int e);
    logic [63:0] m;
    logic [63:0] rem;
    logic [63:0] half;
    logic        up;
    int          s;
    logic [10:0] ef;
    if (e >= -1022) begin
      m    = t >> 11;
      rem  = {53'd0, t[10:0]};
      half = 64'h400;
      up   = (rem > half) || ((rem == half) && (sticky || m[0]));
      if (up) m = m + 64'd1;
      if (m == 64'h0020_0000_0000_0000) begin
        m = m >> 1;
        e = e + 1;
      end
      if (e > 1023) return DBL_INF;
      ef = 11'(e + 1023);
      return {1'b0, ef, m[51:0]};
    end
    s = 11 + (-1022 - e);
    if (s > 64) return 64'd0;
    if (s == 64) begin
      m    = 64'd0;
      rem  = t;
      half = 64'h8000_0000_0000_0000;
    end else begin
      m    = t >> s;
      rem  = t & ((64'd1 << s) - 64'd1);
      half = 64'd1 << (s - 1);
    end
    up = (rem > half) || ((rem == half) && (sticky || m[0]));
    return up ? m + 64'd1 : m;
  endfunction

  // 10^n rounded to double; elaboration only
  function automatic logic [63:0] pow10_bits(int n);
    logic [BIG_W-1:0] x;
    logic [BIG_W-1:0] r;
    logic [63:0]      t;
    logic             sticky;
    logic             bit_v;
    int               m;
    int               b;
    int               got;
    int               first;
    int               step;
    t      = 64'd0;
    sticky = 1'b0;
    x      = BIG_W'(1);
    r      = BIG_W'(1);
    b      = 0;
    got    = 0;
    first  = 0;
    if (n >= 309) return DBL_INF;
    if (n <= -324) return 64'd0;
    m = (n < 0) ? -n : n;
    for (int i = 0; i < m; i++) x = (x << 2) + x;
    for (int i = 0; i < BIG_W; i++) if (x[i]) b = i + 1;
    if (n >= 0) begin
      if (b >= 64) begin
        t = 64'(x >> (b - 64));
        for (int i = 0; i < b - 64; i++) if (x[i]) sticky = 1'b1;
      end else begin
        t = 64'(x) << (64 - b);
      end
      return round_dbl(t, sticky, b - 1 + m);
    end
    step = 1;
    while ((step <= b + 66) && (got < 64)) begin
      r     = r << 1;
      bit_v = 1'b0;
      if (r >= x) begin
        r     = r - x;
        bit_v = 1'b1;
      end
      if ((got == 0) && bit_v) first = step;
      if ((got > 0) || bit_v) begin
        t   = {t[62:0], bit_v};
        got = got + 1;
      end
      step = step + 1;
    end
    sticky = (r != '0);
    return round_dbl(t, sticky, -first - m);
  endfunction

  // 10^k shifted so its top bit sits at bit 63
  function automatic den_tbl_t build_den_norm();
    den_tbl_t    tb;
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < 16; i++) begin
      tb[i] = p;
      while (!tb[i][63]) tb[i] = tb[i] << 1;
      p = p * 64'd10;
    end
    return tb;
  endfunction

  // bit position of the top bit of 10^k
  function automatic lead_tbl_t build_den_lead();
    lead_tbl_t   tb;
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < 16; i++) begin
      tb[i] = 6'd0;
      for (int j = 0; j < 64; j++) if (p[j]) tb[i] = 6'(j);
      p = p * 64'd10;
    end
    return tb;
  endfunction

endpackage
`default_nettype wire

>>> hdl/dstd_char_if.sv
`default_nettype none
interface dstd_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface
`default_nettype wire

>>> hdl/dstd_dbl_if.sv
`default_nettype none
interface dstd_dbl_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        too_long;
  modport source(output valid, output value_bits, output too_long, input ready);
  modport sink(input valid, input value_bits, input too_long, output ready);
endinterface
`default_nettype wire

>>> hdl/decimal_scientific_text_to_double.sv
`default_nettype none
// Channel   Role    Payload                      Transfer
// char_in   sink    char_code[7:0], last_char    valid & ready
// dbl_out   source  value_bits[63:0], too_long   valid & ready
//
// Characters take one cycle each while ready is high.
// After the last character the result passes through a 56-step
// restoring divider for digits / 10^k, two rounding steps, a split 24x53
// multiply and iterative normalize / denormalize shifters. A zero mantissa
// goes straight to the output; a zero or infinite scale factor skips the multiply.
// An overlong string goes straight to the output register.
// rst is synchronous, active high; no clearing pass is needed.
// A stalled result holds in the output register while the next string parses.
module decimal_scientific_text_to_double import dstd_pkg::*; #(
  parameter int MAX_LENGTH = 10,
  parameter int EXP_LIMIT  = 400
) (
  input wire logic   clk,
  input wire logic   rst,
  dstd_char_if.sink  char_in,
  dstd_dbl_if.source dbl_out
);

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer: parse phase, length count, conversion steps, output valid
  dstd_ctrl #(
    .MAX_LENGTH(MAX_LENGTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .last_char(char_in.last_char),
    .in_ready (char_in.ready),
    .out_valid(dbl_out.valid),
    .out_ready(dbl_out.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: digit accumulators, 10^n table, divider, multiplier, packing
  dstd_dp #(
    .MAX_LENGTH(MAX_LENGTH),
    .EXP_LIMIT (EXP_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_in.char_code),
    .cmd       (cmd),
    .stat      (stat),
    .value_bits(dbl_out.value_bits),
    .too_long  (dbl_out.too_long)
  );

endmodule
`default_nettype wire

>>> hdl/dstd_dp.sv
`default_nettype none
module dstd_dp import dstd_pkg::*; #(
  parameter int MAX_LENGTH = 10,
  parameter int EXP_LIMIT  = 400
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_code,
  input  wire cmd_t        cmd,
  output      stat_t       stat,
  output      logic [63:0] value_bits,
  output      logic        too_long
);

  localparam int MW        = dec_bits(MAX_LENGTH);
  localparam int EW        = $clog2(EXP_LIMIT + 1);
  localparam int ROM_DEPTH = 2 * EXP_LIMIT + 1;
  localparam int AW        = $clog2(ROM_DEPTH);

  typedef logic [63:0] pow_rom_t [ROM_DEPTH];

  function automatic pow_rom_t build_rom();
    pow_rom_t tb;
    for (int i = 0; i < ROM_DEPTH; i++) tb[i] = pow10_bits(i - EXP_LIMIT);
    return tb;
  endfunction

  localparam pow_rom_t  POW_ROM  = build_rom();
  localparam den_tbl_t  DEN_NORM = build_den_norm();
  localparam lead_tbl_t DEN_LEAD = build_den_lead();

  // parse state
  logic [MW-1:0] mant;
  logic          mneg;
  logic [3:0]    fcnt;
  logic          eneg;
  logic [EW-1:0] emag;

  // conversion datapath
  logic [63:0]        vn;
  logic [5:0]         sv;
  logic [64:0]        rr;
  logic [55:0]        qq;
  logic [52:0]        m53;
  logic signed [8:0]  e53;
  logic [23:0]        fm;
  logic signed [8:0]  fe;
  logic [63:0]        tb_q;
  logic [63:0]        tsel;
  logic               has_exp;
  logic [PROD_W-1:0]  pp;
  logic [6:0]         sp;
  logic signed [12:0] xexp;
  logic [11:0]        base;
  logic               ovf;
  logic [6:0]         rem;
  logic               stk;

  // character classes
  logic [3:0] dval;
  assign dval = 4'(char_code - CH_ZERO);

  always_comb begin
    stat           = '0;
    stat.dig       = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    stat.spc       = (char_code == CH_SPACE) || ((char_code >= CH_TAB) && (char_code <= CH_CR));
    stat.plus      = (char_code == CH_PLUS);
    stat.minus     = (char_code == CH_MINUS);
    stat.dot       = (char_code == CH_DOT);
    stat.elet      = (char_code == CH_LC_E) || (char_code == CH_UC_E);
    stat.frac_full = (fcnt == 4'(FRAC_MAX));
    stat.mant_zero = (mant == '0);
    stat.v_norm    = vn[63];
    stat.p_norm    = pp[PROD_W-1];
    stat.shr_done  = (rem == 7'd0);
    stat.t_special = (tsel == DBL_INF) || (tsel == 64'd0);
  end

  // digit accumulation
  logic [MW+3:0] mant_mul;
  logic [EW+3:0] emag_mul;
  assign mant_mul = {1'b0, mant, 3'b0} + {3'b0, mant, 1'b0} + (MW+4)'(dval);
  assign emag_mul = {1'b0, emag, 3'b0} + {3'b0, emag, 1'b0} + (EW+4)'(dval);

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      mant <= '0;
      mneg <= 1'b0;
      fcnt <= 4'd0;
      eneg <= 1'b0;
      emag <= '0;
    end else begin
      if (cmd.mant_acc) mant <= mant_mul[MW-1:0];
      if (cmd.frac_inc) fcnt <= fcnt + 4'd1;
      if (cmd.set_mneg) mneg <= 1'b1;
      if (cmd.set_eneg) eneg <= 1'b1;
      if (cmd.exp_load) emag <= EW'(dval);
      if (cmd.exp_acc) begin
        emag <= (emag_mul > (EW+4)'(EXP_LIMIT)) ? EW'(EXP_LIMIT) : emag_mul[EW-1:0];
      end
    end
  end

  // power-of-ten table, registered read
  logic [AW-1:0] rom_addr;
  assign rom_addr = eneg ? AW'(EXP_LIMIT) - AW'(emag) : AW'(EXP_LIMIT) + AW'(emag);

  always_ff @(posedge clk) begin
    tb_q <= POW_ROM[rom_addr];
  end

  assign tsel = has_exp ? tb_q : DBL_ONE;

  // rounding helpers
  logic        lead;
  logic [52:0] q_m;
  logic        q_g;
  logic        q_s;
  logic [53:0] q_r;
  logic [24:0] f_r;
  logic        f_up;

  assign lead = qq[55];
  assign q_m  = lead ? qq[55:3] : qq[54:2];
  assign q_g  = lead ? qq[2] : qq[1];
  assign q_s  = (lead ? (|qq[1:0]) : qq[0]) || (rr != '0);
  assign q_r  = {1'b0, q_m} + 54'(q_g && (q_s || q_m[0]));
  assign f_up = m53[28] && ((|m53[27:0]) || m53[29]);
  assign f_r  = {1'b0, m53[52:29]} + 25'(f_up);

  // T decomposition
  logic [10:0]        t_exp;
  logic [52:0]        tm;
  logic signed [12:0] tx;
  assign t_exp = tsel[62:52];
  assign tm    = {(t_exp != 11'd0), tsel[51:0]};
  assign tx    = (t_exp == 11'd0) ? -13'sd1074 : $signed({2'b0, t_exp}) - 13'sd1075;

  logic [47:0] prod_lo_a;
  logic [50:0] prod_lo;
  logic [49:0] prod_hi;
  assign prod_lo_a = 48'd0;
  assign prod_lo   = fm * tm[26:0];
  assign prod_hi   = fm * tm[52:27];

  // exponent of the normalized product
  logic signed [12:0] pe;
  logic signed [12:0] dn;
  assign pe = xexp + 13'sd76 - $signed({6'b0, sp});
  assign dn = -13'sd1022 - pe;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      vn      <= 64'(mant);
      sv      <= 6'd0;
      has_exp <= cmd.use_exp;
    end
    if (cmd.nv_step) begin
      if (vn[63:48] == 16'd0) begin
        vn <= vn << 16;
        sv <= sv + 6'd16;
      end else if (vn[63:60] == 4'd0) begin
        vn <= vn << 4;
        sv <= sv + 6'd4;
      end else begin
        vn <= vn << 1;
        sv <= sv + 6'd1;
      end
    end
    if (cmd.div_init) begin
      rr <= {1'b0, vn};
      qq <= 56'd0;
    end
    if (cmd.div_step) begin
      if (rr >= {1'b0, DEN_NORM[fcnt]}) begin
        rr <= (rr - {1'b0, DEN_NORM[fcnt]}) << 1;
        qq <= {qq[54:0], 1'b1};
      end else begin
        rr <= rr << 1;
        qq <= {qq[54:0], 1'b0};
      end
    end
    if (cmd.rnd53) begin
      m53 <= q_r[53] ? 53'h10_0000_0000_0000 : q_r[52:0];
      e53 <= 9'sd63 - $signed({3'b0, sv}) - $signed({3'b0, DEN_LEAD[fcnt]})
             - $signed({8'b0, !lead}) + $signed({8'b0, q_r[53]});
    end
    if (cmd.rnd24) begin
      fm <= f_r[24] ? 24'h80_0000 : f_r[23:0];
      fe <= e53 + $signed({8'b0, f_r[24]});
    end
    if (cmd.mul_lo) begin
      pp   <= PROD_W'(prod_lo) + PROD_W'(prod_lo_a);
      sp   <= 7'd0;
      xexp <= 13'(fe) - 13'sd23 + tx;
    end
    if (cmd.mul_hi) pp <= pp + {prod_hi, 27'd0};
    if (cmd.np_step) begin
      if (pp[PROD_W-1 -: 16] == 16'd0) begin
        pp <= pp << 16;
        sp <= sp + 7'd16;
      end else if (pp[PROD_W-1 -: 4] == 4'd0) begin
        pp <= pp << 4;
        sp <= sp + 7'd4;
      end else begin
        pp <= pp << 1;
        sp <= sp + 7'd1;
      end
    end
    if (cmd.prep_shift) begin
      stk <= 1'b0;
      ovf <= (pe > 13'sd1023);
      if (pe < -13'sd1022) begin
        base <= 12'd0;
        rem  <= (dn > 13'sd57) ? 7'd80 : 7'(dn + 13'sd23);
      end else begin
        base <= 12'(pe + 13'sd1022);
        rem  <= 7'd23;
      end
    end
    if (cmd.shr_step) begin
      if (rem >= 7'd16) begin
        stk <= stk | (|pp[15:0]);
        pp  <= pp >> 16;
        rem <= rem - 7'd16;
      end else if (rem >= 7'd4) begin
        stk <= stk | (|pp[3:0]);
        pp  <= pp >> 4;
        rem <= rem - 7'd4;
      end else begin
        stk <= stk | pp[0];
        pp  <= pp >> 1;
        rem <= rem - 7'd1;
      end
    end
  end

  // final rounding and packing
  logic [52:0] fin_m;
  logic [53:0] fin_r;
  logic [63:0] fin_sum;
  logic        fin_inf;
  logic [63:0] result;
  assign fin_m   = pp[53:1];
  assign fin_r   = {1'b0, fin_m} + 54'(pp[0] && (stk || fin_m[0]));
  assign fin_sum = {base, 52'd0} + 64'(fin_r);
  assign fin_inf = ovf || (fin_sum[63:52] >= 12'd2047);

  always_comb begin
    if (cmd.too_long) begin
      result = DBL_NEG_ONE;
    end else if (tsel == DBL_INF) begin
      result = (mant == '0) ? DBL_QNAN : {mneg, DBL_INF[62:0]};
    end else if ((tsel == 64'd0) || (mant == '0)) begin
      result = {mneg, 63'd0};
    end else if (fin_inf) begin
      result = {mneg, DBL_INF[62:0]};
    end else begin
      result = {mneg, fin_sum[62:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      value_bits <= result;
      too_long   <= cmd.too_long;
    end
  end

endmodule
`default_nettype wire

>>> hdl/dstd_ctrl.sv
`default_nettype none
module dstd_ctrl import dstd_pkg::*; #(
  parameter int MAX_LENGTH = 10
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  input  wire logic  last_char,
  output      logic  in_ready,
  output      logic  out_valid,
  input  wire logic  out_ready,
  input  wire stat_t stat,
  output      cmd_t  cmd
);

  localparam int CW = $clog2(MAX_LENGTH + 2);

  localparam logic [3:0] S_PARSE = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_NV    = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_R53   = 4'd4;
  localparam logic [3:0] S_R24   = 4'd5;
  localparam logic [3:0] S_ML    = 4'd6;
  localparam logic [3:0] S_MH    = 4'd7;
  localparam logic [3:0] S_NP    = 4'd8;
  localparam logic [3:0] S_PS    = 4'd9;
  localparam logic [3:0] S_SHR   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [2:0] PH_LEAD  = 3'd0;
  localparam logic [2:0] PH_INT   = 3'd1;
  localparam logic [2:0] PH_FRAC  = 3'd2;
  localparam logic [2:0] PH_SKIP  = 3'd3;
  localparam logic [2:0] PH_ELEAD = 3'd4;
  localparam logic [2:0] PH_EDIG  = 3'd5;
  localparam logic [2:0] PH_EDONE = 3'd6;

  logic [3:0]    state, state_next;
  logic [2:0]    phase, phase_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          long_q, long_next;
  logic [5:0]    step, step_next;
  logic          ov_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    long_next  = long_q;
    step_next  = step;
    ov_next    = out_valid && !out_ready;
    in_ready   = (state == S_PARSE);
    unique case (state)
      S_PARSE: begin
        if (in_valid) begin
          if (cnt <= CW'(MAX_LENGTH)) cnt_next = cnt + CW'(1);
          if (cnt < CW'(MAX_LENGTH)) begin
            if ((phase <= PH_SKIP) && stat.elet) begin
              phase_next = PH_ELEAD;
            end else begin
              unique case (phase) inside
                PH_LEAD: begin
                  if (stat.spc) begin
                    phase_next = PH_LEAD;
                  end else if (stat.plus) begin
                    phase_next = PH_INT;
                  end else if (stat.minus) begin
                    cmd.set_mneg = 1'b1;
                    phase_next   = PH_INT;
                  end else if (stat.dig) begin
                    cmd.mant_acc = 1'b1;
                    phase_next   = PH_INT;
                  end else if (stat.dot) begin
                    phase_next = PH_FRAC;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
                PH_INT: begin
                  if (stat.dig) cmd.mant_acc = 1'b1;
                  else if (stat.dot) phase_next = PH_FRAC;
                  else phase_next = PH_SKIP;
                end
                PH_FRAC: begin
                  if (stat.dig && !stat.frac_full) begin
                    cmd.mant_acc = 1'b1;
                    cmd.frac_inc = 1'b1;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
                PH_ELEAD: begin
                  if (stat.spc) begin
                    phase_next = PH_ELEAD;
                  end else if (stat.plus) begin
                    phase_next = PH_EDIG;
                  end else if (stat.minus) begin
                    cmd.set_eneg = 1'b1;
                    phase_next   = PH_EDIG;
                  end else if (stat.dig) begin
                    cmd.exp_load = 1'b1;
                    phase_next   = PH_EDIG;
                  end else begin
                    phase_next = PH_EDONE;
                  end
                end
                PH_EDIG: begin
                  if (stat.dig) cmd.exp_acc = 1'b1;
                  else phase_next = PH_EDONE;
                end
                PH_SKIP, PH_EDONE: phase_next = phase;
                default: phase_next = phase;
              endcase
            end
          end
          if (last_char) begin
            long_next  = (cnt_next > CW'(MAX_LENGTH));
            state_next = long_next ? S_OUT : S_LOAD;
          end
        end
      end
      S_LOAD: begin
        cmd.start   = 1'b1;
        cmd.use_exp = (phase >= PH_ELEAD);
        state_next  = stat.mant_zero ? S_OUT : S_NV;
      end
      S_NV: begin
        if (stat.v_norm) begin
          cmd.div_init = 1'b1;
          step_next    = 6'd0;
          state_next   = S_DIV;
        end else begin
          cmd.nv_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 6'd1;
        if (step == 6'(DIV_STEPS - 1)) state_next = S_R53;
      end
      S_R53: begin
        cmd.rnd53  = 1'b1;
        state_next = S_R24;
      end
      S_R24: begin
        cmd.rnd24  = 1'b1;
        state_next = stat.t_special ? S_OUT : S_ML;
      end
      S_ML: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MH;
      end
      S_MH: begin
        cmd.mul_hi = 1'b1;
        state_next = S_NP;
      end
      S_NP: begin
        if (stat.p_norm) state_next = S_PS;
        else cmd.np_step = 1'b1;
      end
      S_PS: begin
        cmd.prep_shift = 1'b1;
        state_next     = S_SHR;
      end
      S_SHR: begin
        if (stat.shr_done) state_next = S_OUT;
        else cmd.shr_step = 1'b1;
      end
      S_OUT: begin
        cmd.too_long = long_q;
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          cmd.clear    = 1'b1;
          ov_next      = 1'b1;
          phase_next   = PH_LEAD;
          cnt_next     = '0;
          long_next    = 1'b0;
          state_next   = S_PARSE;
        end
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PARSE;
      phase     <= PH_LEAD;
      cnt       <= '0;
      long_q    <= 1'b0;
      step      <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      long_q    <= long_next;
      step      <= step_next;
      out_valid <= ov_next;
    end
  end

  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (step == 6'(DIV_STEPS - 1)) |=> (state == S_R53))
    else $error("divider did not stop after the last quotient bit");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> (phase == PH_LEAD) && (cnt == '0) && (state == S_PARSE))
    else $error("parse state not cleared after result load");

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_LENGTH + 1))
    else $error("character count past saturation");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && !out_ready |=> (state == S_OUT) && out_valid)
    else $error("pending result overwritten during stall");

endmodule
`default_nettype wire

>>> tb/tb_decimal_scientific_text_to_double.sv
`default_nettype none
module tb_decimal_scientific_text_to_double import dstd_pkg::*;;

  localparam int  MAXL        = 10;
  localparam int  ELIM        = 400;
  localparam int  CYCLE_LIMIT = 1_000_000;
  localparam int  DRAIN_WAIT  = 200;
  localparam int  RAND_CHARS  = 1400;
  localparam logic [63:0] SGL_INF = 64'h0000_0000_7F80_0000;

  // parser phases, same order as the block's: exponent phases sort last
  typedef enum logic [2:0] {
    PH_LEAD, PH_INT, PH_FRAC, PH_SKIP, PH_ELEAD, PH_EDIG, PH_EDONE
  } phase_e;

  typedef struct {
    logic [63:0] bits;
    logic        flag;
  } dbl_result_t;

  logic clk;
  logic rst;

  dstd_char_if ci();
  dstd_dbl_if  dq();

  decimal_scientific_text_to_double #(
    .MAX_LENGTH(MAXL),
    .EXP_LIMIT (ELIM)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .char_in(ci),
    .dbl_out(dq)
  );

  // predictor state
  phase_e          ph;
  int              char_cnt;
  logic            mant_neg;
  longint unsigned mant_dig;
  int              frac_cnt;
  logic            exp_neg;
  int              exp_mag;

  dbl_result_t pending_doubles[$];
  int          errors;
  int          cycles;
  int          chars_sent;
  bit          sender_idles;
  bit          receiver_idles;
  int          hold_cycles;   // one-shot long stall requested from the receiver side

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic bit is_ws(logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Round (q + sticky) * 2^e2 to a binary format with p significand bits and
  // min_lsb as the subnormal lsb exponent. Result is the magnitude pattern;
  // a carry out of the significand rolls into the exponent field by itself.
  function automatic logic [63:0] round_bin(logic [127:0] q, bit sticky, int e2, int p,
                                            int min_lsb, logic [63:0] inf_pat);
    int           top;
    int           lsb;
    int           sh;
    logic [127:0] m;
    logic [127:0] rem;
    logic [127:0] half;
    logic [63:0]  bits;
    bit           up;
    top = -1;
    if (q == '0) return 64'd0;
    for (int i = 127; i >= 0; i--) if (q[i] && top < 0) top = i;
    lsb = top + e2 - (p - 1);
    if (lsb < min_lsb) lsb = min_lsb;
    sh = lsb - e2;
    if (sh <= 0) begin
      m = q << (-sh);
    end else if (sh > 127) begin
      m = '0;   // far below half an ulp
    end else begin
      m    = q >> sh;
      rem  = q & ((128'd1 << sh) - 128'd1);
      half = 128'd1 << (sh - 1);
      up   = (rem > half) || (rem == half && (sticky || m[0]));
      if (up) m = m + 128'd1;
    end
    bits = (64'(lsb - min_lsb) << (p - 1)) + m[63:0];
    if (bits >= inf_pat) bits = inf_pat;
    return bits;
  endfunction

  // 10^n as a nearest-even double, exact big-integer arithmetic
  function automatic logic [63:0] ten_pow_dbl(int n);
    logic [1023:0] x;
    logic [1023:0] num;
    logic [1023:0] quo;
    logic [1023:0] rmd;
    int            m;
    int            b;
    int            sh;
    bit            st;
    if (n >= 309) return DBL_INF;
    if (n <= -324) return 64'd0;
    m = n < 0 ? -n : n;
    x = 1024'd1;
    for (int i = 0; i < m; i++) x = x * 5;
    b = 0;
    for (int i = 0; i < 1024; i++) if (x[i]) b = i + 1;
    if (n >= 0) begin
      sh = b > 100 ? b - 100 : 0;
      st = ((x >> sh) << sh) != x;
      return round_bin(128'(x >> sh), st, n + sh, 53, -1074, DBL_INF);
    end
    // 2^-m / 5^m via a quotient with about 100 significant bits
    num = 1024'd1 << (b + 100);
    quo = num / x;
    rmd = num % x;
    return round_bin(quo[127:0], rmd != '0, -m - (b + 100), 53, -1074, DBL_INF);
  endfunction

  function automatic logic [63:0] convert_string();
    real          v;
    real          scale;
    logic [63:0]  qb;
    logic [63:0]  fb;
    logic [63:0]  dmag;
    logic [63:0]  fd;
    logic [63:0]  tb;
    logic [127:0] q;
    int           e2;
    v     = real'(mant_dig);
    scale = 1.0;
    for (int i = 0; i < frac_cnt; i++) scale = scale * 10.0;
    qb = $realtobits((mant_neg ? -v : v) / scale);
    // narrow to single precision
    if (qb[62:52] == 0) begin
      q  = 128'(qb[51:0]);
      e2 = -1074;
    end else begin
      q  = 128'({1'b1, qb[51:0]});
      e2 = int'(qb[62:52]) - 1075;
    end
    fb = round_bin(q, 1'b0, e2, 24, -149, SGL_INF);
    // widen back, exact
    if (fb[30:23] == 0) begin
      q  = 128'(fb[22:0]);
      e2 = -149;
    end else begin
      q  = 128'({1'b1, fb[22:0]});
      e2 = int'(fb[30:23]) - 150;
    end
    dmag = round_bin(q, 1'b0, e2, 53, -1074, DBL_INF);
    fd   = {qb[63], dmag[62:0]};
    if (ph < PH_ELEAD) return fd;
    tb = ten_pow_dbl(exp_neg ? -exp_mag : exp_mag);
    if (tb == DBL_INF && fb[30:0] == 0) return DBL_QNAN;   // zero times infinity
    return $realtobits($bitstoreal(fd) * $bitstoreal(tb));
  endfunction

  function automatic void clear_parser();
    ph       = PH_LEAD;
    char_cnt = 0;
    mant_neg = 1'b0;
    mant_dig = 0;
    frac_cnt = 0;
    exp_neg  = 1'b0;
    exp_mag  = 0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int t;
    if (ph <= PH_SKIP && (c == CH_LC_E || c == CH_UC_E)) begin
      ph = PH_ELEAD;
      return;
    end
    case (ph)
      PH_LEAD: begin
        if (is_ws(c)) ;
        else if (c == CH_PLUS) ph = PH_INT;
        else if (c == CH_MINUS) begin
          mant_neg = 1'b1;
          ph       = PH_INT;
        end else if (is_dig(c)) begin
          mant_dig = mant_dig * 10 + (c - CH_ZERO);
          ph       = PH_INT;
        end else if (c == CH_DOT) ph = PH_FRAC;
        else ph = PH_SKIP;
      end
      PH_INT: begin
        if (is_dig(c)) mant_dig = mant_dig * 10 + (c - CH_ZERO);
        else if (c == CH_DOT) ph = PH_FRAC;
        else ph = PH_SKIP;
      end
      PH_FRAC: begin
        if (is_dig(c) && frac_cnt < FRAC_MAX) begin
          mant_dig = mant_dig * 10 + (c - CH_ZERO);
          frac_cnt++;
        end else ph = PH_SKIP;
      end
      PH_ELEAD: begin
        if (is_ws(c)) ;
        else if (c == CH_PLUS) ph = PH_EDIG;
        else if (c == CH_MINUS) begin
          exp_neg = 1'b1;
          ph      = PH_EDIG;
        end else if (is_dig(c)) begin
          exp_mag = c - CH_ZERO;
          ph      = PH_EDIG;
        end else ph = PH_EDONE;
      end
      PH_EDIG: begin
        if (is_dig(c)) begin
          t       = exp_mag * 10 + (c - CH_ZERO);
          exp_mag = t > ELIM ? ELIM : t;
        end else ph = PH_EDONE;
      end
      default: ;
    endcase
  endfunction

  // one accepted character transaction
  function automatic void predict_char(logic [7:0] c, logic last);
    dbl_result_t r;
    if (char_cnt <= MAXL) char_cnt++;
    if (char_cnt <= MAXL) parse_char(c);
    if (!last) return;
    if (char_cnt > MAXL) begin
      r.bits = DBL_NEG_ONE;
      r.flag = 1'b1;
    end else begin
      r.bits = convert_string();
      r.flag = 1'b0;
    end
    pending_doubles.push_back(r);
    clear_parser();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  task automatic send_char(input logic [7:0] c, input logic last);
    int gap;
    gap = sender_idles ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      ci.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ci.valid     <= 1'b1;
    ci.char_code <= c;
    ci.last_char <= last;
    @(posedge clk);
    while (!ci.ready) @(posedge clk);
    predict_char(c, last);
    chars_sent++;
  endtask

  task automatic send_string(input byte s[$]);
    for (int i = 0; i < s.size(); i++) send_char(s[i], i == s.size() - 1);
  endtask

  task automatic send_text(input string s);
    byte b[$];
    for (int i = 0; i < s.len(); i++) b.push_back(s[i]);
    send_string(b);
  endtask

  // sender pauses until every expected result is back
  task automatic wait_drained();
    ci.valid <= 1'b0;
    @(posedge clk);
    while (pending_doubles.size() != 0) @(posedge clk);
  endtask

  function automatic byte rand_digit();
    return byte'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic byte rand_ws();
    return $urandom_range(0, 1) ? byte'(CH_SPACE) : byte'($urandom_range(CH_TAB, CH_CR));
  endfunction

  // mostly well-formed number text with random content, sometimes garbage
  function automatic void build_number(ref byte s[$]);
    int nd;
    s.delete();
    if ($urandom_range(0, 9) == 0) begin
      nd = $urandom_range(1, 14);
      for (int i = 0; i < nd; i++) s.push_back(byte'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 4) == 0) s.push_back(rand_ws());
    case ($urandom_range(0, 2))
      0: s.push_back(byte'(CH_MINUS));
      1: s.push_back(byte'(CH_PLUS));
      default: ;
    endcase
    nd = $urandom_range(0, 5);
    for (int i = 0; i < nd; i++) s.push_back(rand_digit());
    if ($urandom_range(0, 1)) begin
      s.push_back(byte'(CH_DOT));
      nd = $urandom_range(0, 4);
      for (int i = 0; i < nd; i++) s.push_back(rand_digit());
    end
    if ($urandom_range(0, 6) == 0) s.push_back(byte'($urandom_range(0, 255)));
    if ($urandom_range(0, 2) != 0) begin
      s.push_back($urandom_range(0, 1) ? byte'(CH_LC_E) : byte'(CH_UC_E));
      if ($urandom_range(0, 7) == 0) s.push_back(rand_ws());
      case ($urandom_range(0, 2))
        0: s.push_back(byte'(CH_MINUS));
        1: s.push_back(byte'(CH_PLUS));
        default: ;
      endcase
      nd = $urandom_range(0, 3);
      for (int i = 0; i < nd; i++) s.push_back(rand_digit());
    end
    if (s.size() == 0) s.push_back(rand_digit());
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int          stall;
    dbl_result_t exp_r;
    dq.ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = receiver_idles ? $urandom_range(0, 10) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        dq.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dq.ready <= 1'b1;
      @(posedge clk);
      while (!dq.valid) @(posedge clk);
      if (pending_doubles.size() == 0) begin
        report($sformatf("unexpected result %h too_long=%b", dq.value_bits, dq.too_long));
      end else begin
        exp_r = pending_doubles.pop_front();
        if (dq.value_bits !== exp_r.bits)
          report($sformatf("value_bits %h, expected %h", dq.value_bits, exp_r.bits));
        if (dq.too_long !== exp_r.flag)
          report($sformatf("too_long %b, expected %b", dq.too_long, exp_r.flag));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    byte s[$];
    send_text("0");
    send_text("-");                 // empty mantissa keeps its sign
    send_text("-0");
    send_text("1.5");
    send_text(" \t+12.25e3");
    send_text("9999999999");        // longest digit string that fits
    send_text("12345678901");       // one past the limit
    send_text("1e400");             // overflow to infinity
    send_text("1e-400");            // underflow to zero
    send_text("0e400");             // zero times infinity
    send_text("5e-324");
    send_text("3e-310");            // subnormal scale factor
    send_text("1.7E308");
    send_text("1e99999");           // exponent saturates
    send_text("-2e-99999");
    send_text(".");
    send_text("\v-.5E-2");
    send_text("1x2e5");             // junk before the exponent letter
    send_text("1ee2");
    send_text("4e+");
    send_text("4e -3");
    send_text("e");
    s = '{8'd49, 8'd0, 8'd50};      // NUL ends the mantissa
    send_string(s);
    s = '{8'd255, 8'd128, 8'd55};
    send_string(s);
    s = '{8'd55, 8'd101, 8'd50, 8'd0};
    send_string(s);
  endtask

  // long receiver stall while characters keep coming: input must back up
  task automatic test_backpressure();
    byte s[$];
    wait_drained();
    hold_cycles = 400;
    for (int i = 0; i < 8; i++) begin
      build_number(s);
      send_string(s);
    end
    wait_drained();
  endtask

  task automatic test_random(input int n_chars);
    byte s[$];
    int  stop_at;
    stop_at = chars_sent + n_chars;
    while (chars_sent < stop_at) begin
      // occasional stretches with no idling on either side
      sender_idles   = $urandom_range(0, 5) != 0;
      receiver_idles = $urandom_range(0, 5) != 0;
      for (int i = 0; i < 10; i++) begin
        build_number(s);
        if ($urandom_range(0, 11) == 0)
          for (int k = 0; k < 5; k++) s.push_back(rand_digit());   // five more digits, which can push it past MAXL
        send_string(s);
      end
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  initial begin
    errors         = 0;
    cycles         = 0;
    chars_sent     = 0;
    hold_cycles    = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    clear_parser();
    rst          <= 1'b1;
    ci.valid     <= 1'b0;
    ci.char_code <= 8'd0;
    ci.last_char <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random(RAND_CHARS);

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
